// ===== rtl/core/lwfe_pkg.sv =====
package lwfe_pkg;

  localparam logic [7:0] CMD_COLUMN   = 8'h2A;
  localparam logic [7:0] CMD_PAGE     = 8'h2B;
  localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

  localparam logic [3:0] PH_COL     = 4'd0;
  localparam logic [3:0] PH_XS_HI   = 4'd1;
  localparam logic [3:0] PH_XS_LO   = 4'd2;
  localparam logic [3:0] PH_XE_HI   = 4'd3;
  localparam logic [3:0] PH_XE_LO   = 4'd4;
  localparam logic [3:0] PH_PAGE    = 4'd5;
  localparam logic [3:0] PH_YS_HI   = 4'd6;
  localparam logic [3:0] PH_YS_LO   = 4'd7;
  localparam logic [3:0] PH_YE_HI   = 4'd8;
  localparam logic [3:0] PH_YE_LO   = 4'd9;
  localparam logic [3:0] PH_MEMWR   = 4'd10;
  localparam logic [3:0] PH_PIXELS  = 4'd11;

  localparam logic [0:0] OP_START = 1'b0;
  localparam logic [0:0] OP_TICK  = 1'b1;

  localparam logic [0:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [0:0] REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [15:0] SCREEN_WIDTH_RESET  = 16'd480;
  localparam logic [15:0] SCREEN_HEIGHT_RESET = 16'd320;

  typedef enum logic [1:0] {
    KIND_BUS_WORD = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_REJECTED = 2'd2,
    KIND_DROPPED  = 2'd3
  } kind_t;

  typedef struct packed {
    logic        on_screen;
    logic [15:0] width;
    logic [15:0] height;
    logic [15:0] x_end;
    logic [15:0] y_end;
  } clip_t;

endpackage

// ===== rtl/core/lwfe_clip.sv =====
module lwfe_clip (
  input  logic [15:0]    x,
  input  logic [15:0]    y,
  input  logic [15:0]    width,
  input  logic [15:0]    height,
  input  logic [15:0]    screen_width,
  input  logic [15:0]    screen_height,
  output lwfe_pkg::clip_t clip
);
  import lwfe_pkg::*;

  logic [16:0] x_sum;
  logic [16:0] y_sum;
  logic [15:0] w_c;
  logic [15:0] h_c;

  always_comb begin
    x_sum = {1'b0, x} + {1'b0, width};
    y_sum = {1'b0, y} + {1'b0, height};
    w_c = (x_sum > {1'b0, screen_width}) ? (screen_width - x) : width;
    h_c = (y_sum > {1'b0, screen_height}) ? (screen_height - y) : height;
    clip.on_screen = (x < screen_width) && (y < screen_height);
    clip.width     = w_c;
    clip.height    = h_c;
    clip.x_end     = x + w_c - 16'd1;
    clip.y_end     = y + h_c - 16'd1;
  end

endmodule

// ===== rtl/core/lcd_window_fill_engine.sv =====
// Window fill engine for a parallel LCD panel bus.
// Input stream: tuser selects a start request (0) or a bus slot tick (1);
// tdata carries x, y, width, height and color. A start answers with one
// word of kind accepted, rejected (corner off screen) or dropped (fill in
// progress). Each tick during a fill answers with one panel bus word:
// column command, x start/end bytes, page command, y start/end bytes,
// memory-write command, then the color once per pixel; tlast marks the
// final word. A tick while idle gives nothing.
// Every item is handled combinationally and lands in the output register
// when it is accepted: one item per cycle sustained while the receiver
// keeps taking words. The pixel count multiply runs in the cycle after a
// start, hidden behind the eleven window words.
// The input is ready whenever the output register is empty or being taken,
// so a stalled receiver holds the current word and back-pressures the input.
// Reset (synchronous, rst high) ends any fill, empties the output register
// and restores the screen size to 480 by 320. Screen size writes through
// the cfg port apply to later start requests.
module lcd_window_fill_engine #(
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // x, y, width, height, color
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // bus_word, is_command, zero pad
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import lwfe_pkg::*;

  logic [15:0] screen_width;
  logic [15:0] screen_height;

  logic                  busy;
  logic [3:0]            phase;
  logic [15:0]           win_x_start;
  logic [15:0]           win_x_end;
  logic [15:0]           win_y_start;
  logic [15:0]           win_y_end;
  logic [15:0]           fill_color;
  logic [COUNT_BITS-1:0] pixels_left;
  logic [15:0]           clip_w;
  logic [15:0]           clip_h;
  logic                  mul_pending;
  logic [31:0]           product;

  logic        out_valid;
  kind_t       out_kind;
  logic [15:0] out_word;
  logic        out_cmd;
  logic        out_last;

  logic        op;
  logic [15:0] in_x;
  logic [15:0] in_y;
  logic [15:0] in_w;
  logic [15:0] in_h;
  logic [15:0] in_c;
  clip_t       clip;
  logic        accept;

  logic                  has_result;
  kind_t                 kind_next;
  logic [15:0]           word_next;
  logic                  cmd_next;
  logic                  last_next;
  logic                  start_fill;
  logic [COUNT_BITS-1:0] pixels_left_next;

  assign op   = s_axis_tuser;
  assign in_x = s_axis_tdata[15:0];
  assign in_y = s_axis_tdata[31:16];
  assign in_w = s_axis_tdata[47:32];
  assign in_h = s_axis_tdata[63:48];
  assign in_c = s_axis_tdata[79:64];

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lwfe_clip u_clip (
    .x             (in_x),
    .y             (in_y),
    .width         (in_w),
    .height        (in_h),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .clip          (clip)
  );

  assign product = 32'(clip_w) * 32'(clip_h);

  always_comb begin
    has_result       = 1'b0;
    kind_next        = KIND_BUS_WORD;
    word_next        = '0;
    cmd_next         = 1'b0;
    last_next        = 1'b0;
    start_fill       = 1'b0;
    pixels_left_next = pixels_left;
    if (op == OP_START) begin
      has_result = 1'b1;
      if (busy) begin
        kind_next = KIND_DROPPED;
      end else if (!clip.on_screen) begin
        kind_next = KIND_REJECTED;
      end else begin
        kind_next  = KIND_ACCEPTED;
        start_fill = 1'b1;
      end
    end else if (busy) begin
      has_result = 1'b1;
      unique case (phase)
        PH_COL: begin
          word_next = 16'(CMD_COLUMN);
          cmd_next  = 1'b1;
        end
        PH_XS_HI: word_next = {8'd0, win_x_start[15:8]};
        PH_XS_LO: word_next = {8'd0, win_x_start[7:0]};
        PH_XE_HI: word_next = {8'd0, win_x_end[15:8]};
        PH_XE_LO: word_next = {8'd0, win_x_end[7:0]};
        PH_PAGE: begin
          word_next = 16'(CMD_PAGE);
          cmd_next  = 1'b1;
        end
        PH_YS_HI: word_next = {8'd0, win_y_start[15:8]};
        PH_YS_LO: word_next = {8'd0, win_y_start[7:0]};
        PH_YE_HI: word_next = {8'd0, win_y_end[15:8]};
        PH_YE_LO: word_next = {8'd0, win_y_end[7:0]};
        PH_MEMWR: begin
          word_next = 16'(CMD_MEMWRITE);
          cmd_next  = 1'b1;
          last_next = (pixels_left == '0);
        end
        default: begin
          word_next = fill_color;
          if (pixels_left != '0) begin
            pixels_left_next = pixels_left - COUNT_BITS'(1);
          end
          last_next = (pixels_left_next == '0);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      phase       <= PH_COL;
      mul_pending <= 1'b0;
    end else begin
      mul_pending <= 1'b0;
      if (accept) begin
        if (start_fill) begin
          busy        <= 1'b1;
          phase       <= PH_COL;
          mul_pending <= 1'b1;
        end else if (op == OP_TICK && busy) begin
          if (last_next) begin
            busy  <= 1'b0;
            phase <= PH_COL;
          end else if (phase < PH_PIXELS) begin
            phase <= phase + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && start_fill) begin
      win_x_start <= in_x;
      win_y_start <= in_y;
      win_x_end   <= clip.x_end;
      win_y_end   <= clip.y_end;
      fill_color  <= in_c;
      clip_w      <= clip.width;
      clip_h      <= clip.height;
    end
    if (mul_pending) begin
      pixels_left <= product[COUNT_BITS-1:0];
    end else if (accept && op == OP_TICK && busy) begin
      pixels_left <= pixels_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= has_result;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_kind <= kind_next;
      out_word <= word_next;
      out_cmd  <= cmd_next;
      out_last <= last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_cmd, out_word};
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lwfe_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [0:0]  op;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
  } fill_req_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] bus_word;
    logic        is_command;
    logic        last;
  } panel_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // x, y, width, height, color
  logic        s_axis_tuser = 1'b0;  // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // bus_word, is_command, zero pad
  logic [1:0]  m_axis_tuser;  // kind
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  lcd_window_fill_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fill_req_t   fill_reqs[$];
  panel_word_t panel_words_due[$];
  fill_req_t   on_bus;
  logic        steady = 1'b0;
  int          mismatches = 0;
  int          quiet = 0;

  logic [15:0] scr_w = SCREEN_WIDTH_RESET;
  logic [15:0] scr_h = SCREEN_HEIGHT_RESET;
  logic        fill_busy = 1'b0;
  logic [3:0]  fill_phase = PH_COL;
  logic [15:0] win_xs = '0;
  logic [15:0] win_xe = '0;
  logic [15:0] win_ys = '0;
  logic [15:0] win_ye = '0;
  logic [15:0] fill_color = '0;
  logic [31:0] pixels_left = '0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic predict_panel_words(input fill_req_t r);
    logic [16:0] reach_x;
    logic [16:0] reach_y;
    logic [15:0] cw;
    logic [15:0] ch;
    panel_word_t pw;
    pw = '{KIND_BUS_WORD, 16'd0, 1'b0, 1'b0};
    if (r.op == OP_START) begin
      if (fill_busy) begin
        pw.kind = KIND_DROPPED;
      end else if (r.x >= scr_w || r.y >= scr_h) begin
        pw.kind = KIND_REJECTED;
      end else begin
        cw = r.w;
        ch = r.h;
        reach_x = {1'b0, r.x} + {1'b0, r.w} - 17'd1;
        reach_y = {1'b0, r.y} + {1'b0, r.h} - 17'd1;
        if (r.w != 16'd0 && reach_x >= {1'b0, scr_w}) cw = scr_w - r.x;
        if (r.h != 16'd0 && reach_y >= {1'b0, scr_h}) ch = scr_h - r.y;
        win_xs = r.x;
        win_ys = r.y;
        win_xe = r.x + cw - 16'd1;
        win_ye = r.y + ch - 16'd1;
        fill_color = r.color;
        pixels_left = {16'd0, cw} * {16'd0, ch};
        fill_phase = PH_COL;
        fill_busy = 1'b1;
        pw.kind = KIND_ACCEPTED;
      end
      panel_words_due.push_back(pw);
    end else if (fill_busy) begin
      case (fill_phase)
        PH_COL: begin
          pw.bus_word = {8'd0, CMD_COLUMN};
          pw.is_command = 1'b1;
        end
        PH_XS_HI: pw.bus_word = {8'd0, win_xs[15:8]};
        PH_XS_LO: pw.bus_word = {8'd0, win_xs[7:0]};
        PH_XE_HI: pw.bus_word = {8'd0, win_xe[15:8]};
        PH_XE_LO: pw.bus_word = {8'd0, win_xe[7:0]};
        PH_PAGE: begin
          pw.bus_word = {8'd0, CMD_PAGE};
          pw.is_command = 1'b1;
        end
        PH_YS_HI: pw.bus_word = {8'd0, win_ys[15:8]};
        PH_YS_LO: pw.bus_word = {8'd0, win_ys[7:0]};
        PH_YE_HI: pw.bus_word = {8'd0, win_ye[15:8]};
        PH_YE_LO: pw.bus_word = {8'd0, win_ye[7:0]};
        PH_MEMWR: begin
          pw.bus_word = {8'd0, CMD_MEMWRITE};
          pw.is_command = 1'b1;
          pw.last = (pixels_left == 32'd0);
        end
        default: begin
          pw.bus_word = fill_color;
          if (pixels_left != 32'd0) pixels_left = pixels_left - 32'd1;
          pw.last = (pixels_left == 32'd0);
        end
      endcase
      if (fill_phase < PH_PIXELS) fill_phase = fill_phase + 4'd1;
      if (pw.last) begin
        fill_busy = 1'b0;
        fill_phase = PH_COL;
      end
      panel_words_due.push_back(pw);
    end
  endtask

  // feed the input stream from the pending queue; hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_panel_words(on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (fill_reqs.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
          on_bus = fill_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= on_bus.op;
          s_axis_tdata <= {on_bus.color, on_bus.h, on_bus.w, on_bus.y, on_bus.x};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : word_check
    panel_word_t seen;
    panel_word_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind = kind_t'(m_axis_tuser);
        seen.bus_word = m_axis_tdata[15:0];
        seen.is_command = m_axis_tdata[16];
        seen.last = m_axis_tlast;
        if (panel_words_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected word: kind %0d data %h cmd %b last %b",
                                  seen.kind, seen.bus_word, seen.is_command, seen.last));
        end else begin
          want = panel_words_due.pop_front();
          if (seen.kind != want.kind)
            flag_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
          if (seen.bus_word != want.bus_word)
            flag_mismatch($sformatf("bus word %h, want %h", seen.bus_word, want.bus_word));
          if (seen.is_command != want.is_command)
            flag_mismatch($sformatf("command flag %b, want %b",
                                    seen.is_command, want.is_command));
          if (seen.last != want.last)
            flag_mismatch($sformatf("last %b, want %b", seen.last, want.last));
        end
      end
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("stream stalled for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_req(input logic [0:0] op, input logic [15:0] x, input logic [15:0] y,
                          input logic [15:0] w, input logic [15:0] h,
                          input logic [15:0] color);
    fill_req_t r;
    r = '{op, x, y, w, h, color};
    fill_reqs.push_back(r);
  endtask

  task automatic push_ticks(input int n);
    repeat (n)
      push_req(OP_TICK, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_SCREEN_WIDTH) scr_w = val;
    else scr_h = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (fill_reqs.size() != 0 || s_axis_tvalid || panel_words_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // pick a corner and a size along one axis that keeps the clipped span small
  task automatic pick_axis(input logic [15:0] size, output logic [15:0] pos,
                           output logic [15:0] len, output int span);
    int room;
    if ($urandom_range(0, 1) == 0) begin
      pos = 16'($urandom_range(0, int'(size) - 1));
      len = 16'($urandom_range(0, 4));
    end else begin
      room = $urandom_range(1, (int'(size) < 6) ? int'(size) : 6);
      pos = size - 16'(room);
      len = 16'($urandom);
    end
    room = int'(size) - int'(pos);
    span = (int'(len) > room) ? room : int'(len);
  endtask

  task automatic plan_fill(inout int budget);
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
    int cw;
    int ch;
    int words;
    int cut;
    pick_axis(scr_w, x, w, cw);
    pick_axis(scr_h, y, h, ch);
    push_req(OP_START, x, y, w, h, 16'($urandom));
    words = 11 + cw * ch;
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(0, words - 1);
      push_ticks(cut);
      push_req(OP_START, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
      push_ticks(words - cut);
      budget -= 1;
    end else begin
      push_ticks(words);
    end
    budget -= words + 1;
  endtask

  task automatic plan_reject(inout int budget);
    if ($urandom_range(0, 1) == 0)
      push_req(OP_START, 16'($urandom_range(int'(scr_w), 65535)), 16'($urandom),
               16'($urandom), 16'($urandom), 16'($urandom));
    else
      push_req(OP_START, 16'($urandom), 16'($urandom_range(int'(scr_h), 65535)),
               16'($urandom), 16'($urandom), 16'($urandom));
    budget -= 1;
  endtask

  initial begin
    logic [15:0] widths[7];
    logic [15:0] heights[7];
    int budget;
    int pick;
    widths = '{16'd7, 16'd1, 16'd65535, 16'd0, 16'd12, 16'd300, 16'd480};
    heights = '{16'd5, 16'd1, 16'd65535, 16'd200, 16'd0, 16'd3, 16'd320};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    push_ticks(1);
    push_req(OP_START, 16'd0, 16'd0, 16'd0, 16'd0, 16'h1234);
    push_ticks(11);
    push_req(OP_START, 16'd479, 16'd319, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_ticks(5);
    push_req(OP_START, 16'd1, 16'd2, 16'd3, 16'd2, 16'h0000);
    push_ticks(7);
    push_req(OP_START, 16'd480, 16'd0, 16'd1, 16'd1, 16'hAAAA);
    push_req(OP_START, 16'd0, 16'd320, 16'd1, 16'd1, 16'h5555);
    push_req(OP_START, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    settle();

    for (int p = 0; p < 7; p++) begin
      write_reg(REG_SCREEN_WIDTH, widths[p]);
      write_reg(REG_SCREEN_HEIGHT, heights[p]);
      steady <= (p == 2);
      budget = (widths[p] == 16'd0 || heights[p] == 16'd0) ? 30 : 100;
      while (budget > 0) begin
        pick = $urandom_range(0, 99);
        if (widths[p] == 16'd0 || heights[p] == 16'd0 || pick < 12) begin
          plan_reject(budget);
        end else if (pick < 20) begin
          push_ticks($urandom_range(1, 3));
        end else begin
          plan_fill(budget);
        end
      end
      settle();
    end

    steady <= 1'b0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
